// ----- rtl/multi_client_heartbeat_watchdog_assert.svh -----
// Assertion shorthands used by the watchdog engine RTL.
`ifndef MULTI_CLIENT_HEARTBEAT_WATCHDOG_ASSERT_SVH
`define MULTI_CLIENT_HEARTBEAT_WATCHDOG_ASSERT_SVH

// Same-cycle implication.
`define MCHW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MCHW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mchw_pkg.sv -----
package mchw_pkg;

   localparam int ENTRIES      = 16;
   localparam int ID_BITS      = 32;
   localparam int SLOT_W       = $clog2(ENTRIES);
   localparam int COUNT_W      = SLOT_W + 1;
   localparam int CNT_W        = 16;
   localparam int CLIENT_ID_W  = 32;
   localparam int SLOT_FIELD_W = 4;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int REG_IDX_W    = 2;

   localparam logic [COUNT_W-1:0] ENTRIES_CNT = COUNT_W'(ENTRIES);
   localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

   localparam logic KIND_TICK      = 1'b0;
   localparam logic KIND_HEARTBEAT = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_KEEPALIVE = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HANG      = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_DRIVE_CHK = 2'd2;

   localparam logic [CNT_W-1:0] KEEPALIVE_RESET = 16'd10;
   localparam logic [CNT_W-1:0] HANG_RESET      = 16'd100;

   typedef struct packed {
      logic                   kind;
      logic [CLIENT_ID_W-1:0] client_id;
      logic                   drive_fault;
   } req_type;

   typedef struct packed {
      logic                    kick;
      logic                    reboot_request;
      logic                    hung;
      logic [SLOT_FIELD_W-1:0] hung_slot;
      logic                    added;
      logic                    table_full;
      logic [SLOT_FIELD_W-1:0] matched_slot;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0] keepalive_interval;
      logic [CNT_W-1:0] hang_limit;
      logic             drive_check_enable;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [CNT_W-1:0]  data;
   } cnt_wr_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  addr;
      logic [ID_BITS-1:0] data;
   } id_wr_type;

   // Keep the low ID_BITS of the incoming identifier, zero above 32 bits.
   function automatic logic [ID_BITS-1:0] id_of(input logic [CLIENT_ID_W-1:0] raw);
      logic [ID_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < ID_BITS; i++) begin
         if (i < CLIENT_ID_W) begin
            r[i] = raw[i % CLIENT_ID_W];
         end
      end
      return r;
   endfunction

   // Low four bits of a slot number, zero-filled for small tables.
   function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
      logic [SLOT_FIELD_W-1:0] r;
      r = '0;
      for (int i = 0; i < SLOT_FIELD_W; i++) begin
         if (i < SLOT_W) begin
            r[i] = s[i % SLOT_W];
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/mchw_ram.sv -----
module mchw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mchw_csr.sv -----
module mchw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mchw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mchw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mchw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output mchw_pkg::cfg_type               cfg
);
   import mchw_pkg::*;

   logic [CNT_W-1:0]     keepalive_ff, keepalive_in;
   logic [CNT_W-1:0]     hang_ff, hang_in;
   logic                 drive_chk_ff, drive_chk_in;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      keepalive_in = keepalive_ff;
      hang_in      = hang_ff;
      drive_chk_in = drive_chk_ff;
      prdata       = '0;
      unique case (idx)
         REG_KEEPALIVE: begin
            prdata = CSR_DATA_W'(keepalive_ff);
            if (wr) begin
               keepalive_in = pwdata[CNT_W-1:0];
            end
         end
         REG_HANG: begin
            prdata = CSR_DATA_W'(hang_ff);
            if (wr) begin
               hang_in = pwdata[CNT_W-1:0];
            end
         end
         REG_DRIVE_CHK: begin
            prdata = CSR_DATA_W'(drive_chk_ff);
            if (wr) begin
               drive_chk_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keepalive_ff <= KEEPALIVE_RESET;
         hang_ff      <= HANG_RESET;
         drive_chk_ff <= 1'b0;
      end else begin
         keepalive_ff <= keepalive_in;
         hang_ff      <= hang_in;
         drive_chk_ff <= drive_chk_in;
      end
   end

   assign cfg.keepalive_interval = keepalive_ff;
   assign cfg.hang_limit         = hang_ff;
   assign cfg.drive_check_enable = drive_chk_ff;

endmodule

// ----- rtl/mchw_engine.sv -----
`include "multi_client_heartbeat_watchdog_assert.svh"

module mchw_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  mchw_pkg::req_type            req_item,
   output logic                         busy,
   output logic                         rsp_valid,
   output mchw_pkg::rsp_type            rsp_item,
   input  mchw_pkg::cfg_type            cfg,
   output mchw_pkg::mem_rd_type         rd,
   input  logic [mchw_pkg::ID_BITS-1:0] id_rdata,
   input  logic [mchw_pkg::CNT_W-1:0]   cnt_rdata,
   output mchw_pkg::id_wr_type          id_wr,
   output mchw_pkg::cnt_wr_type         cnt_wr
);
   import mchw_pkg::*;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type          state_ff, state_in;
   logic               kind_ff, kind_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [COUNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic               data_vld_ff, data_vld_in;
   logic [SLOT_W-1:0]  data_idx_ff, data_idx_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  found_slot_ff, found_slot_in;
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]   interval_ff, interval_in;
   logic               kick_blocked_ff, kick_blocked_in;
   logic               hung_latched_ff, hung_latched_in;
   logic [SLOT_W-1:0]  hung_index_ff, hung_index_in;
   logic               kick_ff, kick_in;
   logic               reboot_ff, reboot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic              fault_hit;
   logic              issue;
   logic              hb_hit;
   logic              scan_done;
   logic [SLOT_W-1:0] new_slot;

   assign new_slot  = entry_count_ff[SLOT_W-1:0];
   assign fault_hit = cfg.drive_check_enable && req_item.drive_fault;
   assign issue     = rd_idx_ff < entry_count_ff;
   assign hb_hit    = data_vld_ff && (kind_ff == KIND_HEARTBEAT) && (id_rdata == id_ff);
   assign scan_done = hb_hit || (!issue && !data_vld_ff);

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      id_in           = id_ff;
      rd_idx_in       = rd_idx_ff;
      data_vld_in     = 1'b0;
      data_idx_in     = data_idx_ff;
      found_in        = found_ff;
      found_slot_in   = found_slot_ff;
      entry_count_in  = entry_count_ff;
      interval_in     = interval_ff;
      kick_blocked_in = kick_blocked_ff;
      hung_latched_in = hung_latched_ff;
      hung_index_in   = hung_index_ff;
      kick_in         = kick_ff;
      reboot_in       = reboot_ff;
      rsp_valid_in    = 1'b0;
      rsp_item_in     = rsp_item_ff;
      rd              = '0;
      id_wr           = '0;
      cnt_wr          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in       = req_item.kind;
               id_in         = id_of(req_item.client_id);
               rd_idx_in     = '0;
               found_in      = 1'b0;
               found_slot_in = '0;
               kick_in       = 1'b0;
               reboot_in     = 1'b0;
               state_in      = ST_SCAN;
               if (req_item.kind == KIND_TICK) begin
                  // fault blocks the kick of this very tick too
                  if (fault_hit) begin
                     reboot_in       = 1'b1;
                     kick_blocked_in = 1'b1;
                  end
                  if (interval_ff >= cfg.keepalive_interval) begin
                     interval_in = '0;
                     kick_in     = !(kick_blocked_ff || fault_hit);
                  end else begin
                     interval_in = interval_ff + 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            // read slot i while slot i-1 is checked and written back
            if (issue && !hb_hit) begin
               rd.en       = 1'b1;
               rd.addr     = rd_idx_ff[SLOT_W-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
               data_vld_in = 1'b1;
               data_idx_in = rd_idx_ff[SLOT_W-1:0];
            end
            if (data_vld_ff && (kind_ff == KIND_TICK)) begin
               if (!found_ff && (cnt_rdata >= cfg.hang_limit)) begin
                  // first hung client keeps its count
                  found_in      = 1'b1;
                  found_slot_in = data_idx_ff;
               end else if (cnt_rdata != CNT_MAX) begin
                  cnt_wr.en   = 1'b1;
                  cnt_wr.addr = data_idx_ff;
                  cnt_wr.data = cnt_rdata + 1'b1;
               end
            end
            if (scan_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_item_in  = '0;
               if (kind_ff == KIND_HEARTBEAT) begin
                  if (hb_hit) begin
                     cnt_wr.en                = 1'b1;
                     cnt_wr.addr              = data_idx_ff;
                     cnt_wr.data              = '0;
                     rsp_item_in.matched_slot = slot_field(data_idx_ff);
                  end else if (entry_count_ff < ENTRIES_CNT) begin
                     id_wr.en                 = 1'b1;
                     id_wr.addr               = new_slot;
                     id_wr.data               = id_ff;
                     cnt_wr.en                = 1'b1;
                     cnt_wr.addr              = new_slot;
                     cnt_wr.data              = '0;
                     entry_count_in           = entry_count_ff + 1'b1;
                     rsp_item_in.added        = 1'b1;
                     rsp_item_in.matched_slot = slot_field(new_slot);
                  end else begin
                     rsp_item_in.table_full = 1'b1;
                  end
               end else begin
                  rsp_item_in.kick           = kick_ff;
                  rsp_item_in.reboot_request = reboot_ff;
                  if (found_ff && !hung_latched_ff) begin
                     hung_latched_in = 1'b1;
                     hung_index_in   = found_slot_ff;
                  end
               end
               rsp_item_in.hung      = hung_latched_in;
               rsp_item_in.hung_slot = slot_field(hung_index_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         kind_ff         <= KIND_TICK;
         id_ff           <= '0;
         rd_idx_ff       <= '0;
         data_vld_ff     <= 1'b0;
         data_idx_ff     <= '0;
         found_ff        <= 1'b0;
         found_slot_ff   <= '0;
         entry_count_ff  <= '0;
         interval_ff     <= '0;
         kick_blocked_ff <= 1'b0;
         hung_latched_ff <= 1'b0;
         hung_index_ff   <= '0;
         kick_ff         <= 1'b0;
         reboot_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_item_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         kind_ff         <= kind_in;
         id_ff           <= id_in;
         rd_idx_ff       <= rd_idx_in;
         data_vld_ff     <= data_vld_in;
         data_idx_ff     <= data_idx_in;
         found_ff        <= found_in;
         found_slot_ff   <= found_slot_in;
         entry_count_ff  <= entry_count_in;
         interval_ff     <= interval_in;
         kick_blocked_ff <= kick_blocked_in;
         hung_latched_ff <= hung_latched_in;
         hung_index_ff   <= hung_index_in;
         kick_ff         <= kick_in;
         reboot_ff       <= reboot_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_item_ff     <= rsp_item_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `MCHW_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "double result strobe")
   `MCHW_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid_ff, "accept did not start a scan")
   `MCHW_ASSERT_IMP(a_no_rw_clash, clock, reset, rd.en && cnt_wr.en, rd.addr != cnt_wr.addr, "counter read and write hit one slot")
   `MCHW_ASSERT_IMP(a_count_range, clock, reset, busy, entry_count_ff <= ENTRIES_CNT, "entry count beyond table")
   `MCHW_ASSERT_NXT(a_hung_sticky, clock, reset, hung_latched_ff, hung_latched_ff && $stable(hung_index_ff), "hung latch moved")

endmodule

// ----- rtl/multi_client_heartbeat_watchdog.sv -----
// Multi-client heartbeat watchdog.
// Input: pulse start with req_item while busy is low. kind selects a tick or a
// heartbeat carrying client_id; drive_fault is looked at on ticks only.
// Output: one item per input on rsp_item, marked by a one-cycle rsp_valid
// pulse; the receiver cannot stall, so the result must be taken in that cycle.
// Config: APB-style slave, keepalive_interval at 0x0, hang_limit at 0x4,
// drive_check_enable at 0x8; pready is tied high. Write only while idle.
// Client IDs and silence counters live in two single-port-read RAMs. Every
// item walks the registered slots through the RAM read port, one slot a
// cycle with the check and write-back of the previous slot overlapped.
// A scan grows with the number of registered clients; a heartbeat that
// matches returns as soon as its slot is read. busy drops in the cycle of
// rsp_valid, so the next item can be taken at the edge that ends it; no new
// item is taken while the previous one is still being scanned.
// Reset empties the client table (entry count zero), clears the interval
// counter, kick block and hung latch, and restores the register defaults.
// The RAMs are not cleared: only slots below the entry count are ever read.
module multi_client_heartbeat_watchdog (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  mchw_pkg::req_type               req_item,
   output logic                            busy,
   output logic                            rsp_valid,
   output mchw_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mchw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mchw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mchw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mchw_pkg::*;

   cfg_type            cfg;
   mem_rd_type         rd;
   id_wr_type          id_wr;
   cnt_wr_type         cnt_wr;
   logic [ID_BITS-1:0] id_rdata;
   logic [CNT_W-1:0]   cnt_rdata;

   mchw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mchw_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (ENTRIES)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (id_wr.en),
      .wr_addr (id_wr.addr),
      .wr_data (id_wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (id_rdata)
   );

   mchw_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ENTRIES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr.en),
      .wr_addr (cnt_wr.addr),
      .wr_data (cnt_wr.data),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (cnt_rdata)
   );

   mchw_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cfg       (cfg),
      .rd        (rd),
      .id_rdata  (id_rdata),
      .cnt_rdata (cnt_rdata),
      .id_wr     (id_wr),
      .cnt_wr    (cnt_wr)
   );

endmodule

// ----- test/watchdog_status_checker.sv -----
module watchdog_status_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  mchw_pkg::req_type               req_item,
   input  logic                            rsp_valid,
   input  mchw_pkg::rsp_type               rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [mchw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mchw_pkg::CSR_DATA_W-1:0] pwdata,
   output int                              errors,
   output int                              pending
);
   import mchw_pkg::*;

   // register copies
   logic [CNT_W-1:0]        ka_limit;
   logic [CNT_W-1:0]        hang_lim;
   logic                    drive_chk;

   // shadow state
   logic [ID_BITS-1:0]      roster [ENTRIES];
   logic [CNT_W-1:0]        silence [ENTRIES];
   int                      roster_len;
   logic [CNT_W-1:0]        interval_cnt;
   logic                    kick_block;
   logic                    hung_seen;
   logic [SLOT_FIELD_W-1:0] hung_at;

   rsp_type                 awaited_status [$];

   function automatic rsp_type tick_outcome(input logic fault);
      rsp_type r;
      int      hit;
      r   = '0;
      hit = -1;
      if (drive_chk && fault) begin
         r.reboot_request = 1'b1;
         kick_block       = 1'b1;
      end
      if (interval_cnt >= ka_limit) begin
         interval_cnt = '0;
         r.kick       = !kick_block;
      end else begin
         interval_cnt = interval_cnt + 1'b1;
      end
      for (int i = 0; i < roster_len; i++) begin
         if (hit < 0 && silence[i] >= hang_lim) begin
            hit = i;
         end
      end
      if (hit >= 0 && !hung_seen) begin
         hung_seen = 1'b1;
         hung_at   = SLOT_FIELD_W'(hit);
      end
      // the first slot at or above the hang limit this tick is held, the rest age and saturate
      for (int i = 0; i < roster_len; i++) begin
         if (i != hit && silence[i] != CNT_MAX) begin
            silence[i] = silence[i] + 1'b1;
         end
      end
      return r;
   endfunction

   function automatic rsp_type heartbeat_outcome(input logic [ID_BITS-1:0] id);
      rsp_type r;
      r = '0;
      for (int i = 0; i < roster_len; i++) begin
         if (roster[i] == id) begin
            silence[i]     = '0;
            r.matched_slot = SLOT_FIELD_W'(i);
            return r;
         end
      end
      if (roster_len < ENTRIES) begin
         roster[roster_len]  = id;
         silence[roster_len] = '0;
         r.added             = 1'b1;
         r.matched_slot      = SLOT_FIELD_W'(roster_len);
         roster_len          = roster_len + 1;
      end else begin
         r.table_full = 1'b1;
      end
      return r;
   endfunction

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         errors = errors + 1;
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ka_limit     = KEEPALIVE_RESET;
         hang_lim     = HANG_RESET;
         drive_chk    = 1'b0;
         roster_len   = 0;
         interval_cnt = '0;
         kick_block   = 1'b0;
         hung_seen    = 1'b0;
         hung_at      = '0;
         errors       = 0;
         awaited_status.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_KEEPALIVE: ka_limit  = pwdata[CNT_W-1:0];
               REG_HANG:      hang_lim  = pwdata[CNT_W-1:0];
               REG_DRIVE_CHK: drive_chk = pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (awaited_status.size() == 0) begin
               errors = errors + 1;
               $display("%0t: result with no item outstanding, expected none got %h",
                        $time, rsp_item);
            end else begin
               want = awaited_status.pop_front();
               report_field("kick", 32'(want.kick), 32'(rsp_item.kick));
               report_field("reboot_request", 32'(want.reboot_request),
                            32'(rsp_item.reboot_request));
               report_field("hung", 32'(want.hung), 32'(rsp_item.hung));
               report_field("hung_slot", 32'(want.hung_slot), 32'(rsp_item.hung_slot));
               report_field("added", 32'(want.added), 32'(rsp_item.added));
               report_field("table_full", 32'(want.table_full), 32'(rsp_item.table_full));
               report_field("matched_slot", 32'(want.matched_slot),
                            32'(rsp_item.matched_slot));
            end
         end
         if (start && !busy) begin
            if (req_item.kind == KIND_HEARTBEAT) begin
               want = heartbeat_outcome(req_item.client_id);
            end else begin
               want = tick_outcome(req_item.drive_fault);
            end
            want.hung      = hung_seen;
            want.hung_slot = hung_at;
            awaited_status.push_back(want);
         end
      end
      pending = awaited_status.size();
   end

endmodule

// ----- test/tb_multi_client_heartbeat_watchdog.sv -----
module tb_multi_client_heartbeat_watchdog;
   import mchw_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TICKS = ENTRIES + 8;
   localparam int PHASE_ITEMS  = 130;

   logic                  clock    = 1'b0;
   logic                  reset    = 1'b1;
   logic                  start    = 1'b0;
   req_type               req_item = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_item;
   logic                  psel     = 1'b0;
   logic                  penable  = 1'b0;
   logic                  pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr    = '0;
   logic [CSR_DATA_W-1:0] pwdata   = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int                    errors;
   int                    pending;
   int                    idle_pct     = 33;
   int                    fault_pct    = 50;
   int                    quiet_cycles = 0;
   logic [CLIENT_ID_W-1:0] issued_ids [$];

   multi_client_heartbeat_watchdog u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   watchdog_status_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .pready    (pready),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .errors    (errors),
      .pending   (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // start may drop on any cycle, busy or not; acceptance is judged mid-cycle
   task automatic issue(input req_type it);
      bit taken;
      taken = 1'b0;
      req_item <= it;
      while (!taken) begin
         if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            start <= 1'b1;
         end
         @(negedge clock);
         taken = start && !busy;
         @(posedge clock);
      end
   endtask

   task automatic send_heartbeat(input logic [CLIENT_ID_W-1:0] id);
      req_type it;
      it.kind        = KIND_HEARTBEAT;
      it.client_id   = id;
      it.drive_fault = 1'($urandom_range(1));
      issue(it);
   endtask

   task automatic send_tick(input logic fault);
      req_type it;
      it.kind        = KIND_TICK;
      it.client_id   = $urandom;
      it.drive_fault = fault;
      issue(it);
   endtask

   // ticks or heartbeats; heartbeats mostly from known clients, now and then a new one
   task automatic random_item;
      logic [CLIENT_ID_W-1:0] id;
      if ($urandom_range(1)) begin
         if (issued_ids.size() != 0 && $urandom_range(99) < 85) begin
            id = issued_ids[$urandom_range(issued_ids.size() - 1)];
         end else begin
            id = $urandom;
            issued_ids.push_back(id);
         end
         send_heartbeat(id);
      end else begin
         send_tick($urandom_range(99) < fault_pct);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [CNT_W-1:0] ka, input logic [CNT_W-1:0] hang,
                            input logic drv, input int idle, input int fault);
      drain();
      csr_write(REG_KEEPALIVE, CSR_DATA_W'(ka));
      csr_write(REG_HANG, CSR_DATA_W'(hang));
      csr_write(REG_DRIVE_CHK, CSR_DATA_W'(drv));
      idle_pct  = idle;
      fault_pct = fault;
      repeat (PHASE_ITEMS) random_item();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: new, repeated and all-ones IDs, ignored fault,
      // then enough ticks to hit the first keepalive
      send_heartbeat(32'h0000_0000);
      send_heartbeat(32'h0000_0000);
      send_heartbeat(32'hFFFF_FFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      send_heartbeat(32'hA5A5_A5A5);
      send_heartbeat(32'hFFFF_FFFF);
      repeat (9) send_tick(1'b0);
      issued_ids.push_back(32'h0000_0000);
      issued_ids.push_back(32'hFFFF_FFFF);
      issued_ids.push_back(32'hA5A5_A5A5);
      repeat (PHASE_ITEMS) random_item();

      // kick on every tick, no idle gaps
      run_phase(16'd0, 16'hFFFF, 1'b0, 0, 50);
      // kick never due, moderate hang limit
      run_phase(16'hFFFF, 16'd40, 1'b0, 33, 50);
      // interval lowered below the running count, tightest nonzero hang limit
      run_phase(16'd5, 16'd1, 1'b0, 33, 50);
      // fault checking on: reboot requests, kicks blocked from then on
      run_phase(16'd2, 16'd0, 1'b1, 33, 10);
      run_phase(16'd7, 16'd300, 1'b0, 33, 50);

      drain();
      repeat (SETTLE_TICKS) @(posedge clock);
      @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
